// ===== rtl/texel_modulate_and_semi_blend_defines.svh =====
// assertion macros for the texel modulate and semi blend block
// expects signals named clock and reset in the scope of each use
`ifndef TEXEL_MODULATE_AND_SEMI_BLEND_DEFINES_SVH
`define TEXEL_MODULATE_AND_SEMI_BLEND_DEFINES_SVH

// condition implies consequence in the same cycle
`define TMSB_ASSERT_SAME(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("tmsb same-cycle check failed");

// condition implies consequence in the following cycle
`define TMSB_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("tmsb next-cycle check failed");

`endif

// ===== rtl/tmsb_pkg.sv =====
// shared types, codes and helpers of the texel modulate and semi blend block
// no dependencies
`default_nettype none

package tmsb_pkg;

   // blend mode codes
   typedef logic [1:0] blend_mode_type;
   localparam blend_mode_type BLEND_AVERAGE = 2'd0;
   localparam blend_mode_type BLEND_ADD     = 2'd1;
   localparam blend_mode_type BLEND_SUB     = 2'd2;
   localparam blend_mode_type BLEND_QUARTER = 2'd3;

   // field constants
   localparam int TEXEL_W    = 16;
   localparam int SEMI_BIT   = 15;
   localparam int CHAN_W     = 8;
   localparam int FIVE_W     = 5;
   localparam int NUM_CHAN   = 3;
   localparam int PROD_W     = 2 * CHAN_W;
   localparam int MOD_SHIFT  = 7;
   localparam logic [FIVE_W-1:0] FIVE_MAX = 5'd31;
   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

   // one colour, index 2 red, 1 green, 0 blue
   typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] color_type;
   typedef logic [NUM_CHAN-1:0][PROD_W-1:0] product_type;

   // per-fragment control that travels down the pipeline
   typedef struct packed {
      logic           transparent;
      logic           blend;
      blend_mode_type mode;
   } frag_ctrl_type;

   // 5 bit to 8 bit channel expansion
   function automatic logic [CHAN_W-1:0] expand5(input logic [FIVE_W-1:0] x);
      return {x, x[FIVE_W-1:FIVE_W-3]};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/tmsb_blend.sv =====
// one colour channel of the semi-transparency blend at 5 bits, clamped and re-expanded
// depends on tmsb_pkg
`default_nettype none

module tmsb_blend (
   input  logic [7:0]              back_chan,
   input  logic [7:0]              front_chan,
   input  tmsb_pkg::blend_mode_type mode,
   output logic [7:0]              blend_chan
);
   import tmsb_pkg::*;

   logic [FIVE_W-1:0] bk;
   logic [FIVE_W-1:0] fr;
   logic [FIVE_W:0]   sum_full;
   logic [FIVE_W:0]   sum_quarter;
   logic [FIVE_W-1:0] result;

   // top five bits of each colour
   assign bk = back_chan[CHAN_W-1:CHAN_W-FIVE_W];
   assign fr = front_chan[CHAN_W-1:CHAN_W-FIVE_W];

   assign sum_full    = {1'b0, bk} + {1'b0, fr};
   assign sum_quarter = {1'b0, bk} + {3'b000, fr[FIVE_W-1:2]};

   // blend and clamp to 0..31
   always_comb begin
      unique case (mode)
         BLEND_AVERAGE: result = sum_full[FIVE_W:1];
         BLEND_ADD:     result = sum_full[FIVE_W] ? FIVE_MAX : sum_full[FIVE_W-1:0];
         BLEND_SUB:     result = (bk < fr) ? '0 : (bk - fr);
         BLEND_QUARTER: result = sum_quarter[FIVE_W] ? FIVE_MAX : sum_quarter[FIVE_W-1:0];
         default:       result = '0;
      endcase
   end

   assign blend_chan = expand5(result);

endmodule

`default_nettype wire

// ===== rtl/texel_modulate_and_semi_blend.sv =====
// top level: four-stage fragment colour pipeline, texel expand, shade modulate, blend
// depends on tmsb_pkg, tmsb_blend and texel_modulate_and_semi_blend_defines.svh
//
//   channel  direction  ports
//   req      in         req_valid/req_ready, texel, shades, flags, mode, back color
//   rsp      out        rsp_valid/rsp_ready, pixel_color, write_enable
//
// one fragment per cycle unless rsp_ready stalls; rsp_valid is the stage 4 valid bit
// stages: texel expand and flags, 8x8 multiply per channel, saturate and select, blend
// each stage holds while its successor is full and stalled; valid bits travel with data
// synchronous reset clears only the stage valid bits
`default_nettype none
`include "texel_modulate_and_semi_blend_defines.svh"

module texel_modulate_and_semi_blend (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [15:0]              req_texel,
   input  logic [7:0]               req_shade_red,
   input  logic [7:0]               req_shade_green,
   input  logic [7:0]               req_shade_blue,
   input  logic                     req_textured,
   input  logic                     req_raw_texture,
   input  logic                     req_semi_enable,
   input  tmsb_pkg::blend_mode_type req_blend_mode,
   input  logic [23:0]              req_back_color,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [23:0]              rsp_pixel_color,
   output logic                     rsp_write_enable
);
   import tmsb_pkg::*;

   // stage valid bits
   logic v1_ff, v1_in;
   logic v2_ff, v2_in;
   logic v3_ff, v3_in;
   logic v4_ff, v4_in;
   logic rdy1, rdy2, rdy3, rdy4;

   // stage 1 payload
   frag_ctrl_type ctrl1_ff, ctrl1_in;
   color_type     tex1_ff, tex1_in;
   color_type     shade1_ff, shade1_in;
   logic          mod1_ff, mod1_in;
   logic          textured1_ff;
   color_type     back1_ff;

   // stage 2 payload
   frag_ctrl_type ctrl2_ff;
   product_type   prod2_ff, prod2_in;
   color_type     pass2_ff, pass2_in;
   logic          mod2_ff;
   color_type     back2_ff;

   // stage 3 payload
   frag_ctrl_type ctrl3_ff;
   color_type     s3_front_ff, s3_front_in;
   color_type     back3_ff;

   // stage 4 payload
   color_type     color4_ff, color4_in;
   logic          we4_ff, we4_in;
   logic          s4_blend_ff;
   color_type     blended;

   // ready chain from the output register back to the input
   assign rdy4      = !v4_ff || rsp_ready;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_ready = rdy1;

   assign v1_in = rdy1 ? req_valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff     : v2_ff;
   assign v3_in = rdy3 ? v2_ff     : v3_ff;
   assign v4_in = rdy4 ? v3_ff     : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // stage 1: texel expansion and fragment flags
   always_comb begin
      ctrl1_in.transparent = req_textured && (req_texel == '0);
      ctrl1_in.blend       = req_semi_enable && (!req_textured || req_texel[SEMI_BIT]);
      ctrl1_in.mode        = req_blend_mode;
      tex1_in[2]           = expand5(req_texel[4:0]);
      tex1_in[1]           = expand5(req_texel[9:5]);
      tex1_in[0]           = expand5(req_texel[14:10]);
      shade1_in            = {req_shade_red, req_shade_green, req_shade_blue};
      mod1_in              = req_textured && !req_raw_texture;
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         ctrl1_ff     <= ctrl1_in;
         tex1_ff      <= tex1_in;
         shade1_ff    <= shade1_in;
         mod1_ff      <= mod1_in;
         textured1_ff <= req_textured;
         back1_ff     <= req_back_color;
      end
   end

   // stage 2: texel times shade per channel, pass-through color
   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         prod2_in[c] = {{CHAN_W{1'b0}}, tex1_ff[c]} * {{CHAN_W{1'b0}}, shade1_ff[c]};
      end
      pass2_in = textured1_ff ? tex1_ff : shade1_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         ctrl2_ff <= ctrl1_ff;
         prod2_ff <= prod2_in;
         pass2_ff <= pass2_in;
         mod2_ff  <= mod1_ff;
         back2_ff <= back1_ff;
      end
   end

   // stage 3: scale by 1/128, saturate, pick the front color
   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         if (!mod2_ff) begin
            s3_front_in[c] = pass2_ff[c];
         end else if (prod2_ff[c][PROD_W-1]) begin
            s3_front_in[c] = CHAN_MAX;
         end else begin
            s3_front_in[c] = prod2_ff[c][PROD_W-2:MOD_SHIFT];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         ctrl3_ff    <= ctrl2_ff;
         s3_front_ff <= s3_front_in;
         back3_ff    <= back2_ff;
      end
   end

   // stage 4: semi-transparency blend per channel
   for (genvar c = 0; c < NUM_CHAN; c++) begin : g_blend
      tmsb_blend u_blend (
         .back_chan  (back3_ff[c]),
         .front_chan (s3_front_ff[c]),
         .mode       (ctrl3_ff.mode),
         .blend_chan (blended[c])
      );
   end

   always_comb begin
      we4_in = !ctrl3_ff.transparent;
      if (ctrl3_ff.transparent) begin
         color4_in = '0;
      end else if (ctrl3_ff.blend) begin
         color4_in = blended;
      end else begin
         color4_in = s3_front_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         color4_ff   <= color4_in;
         we4_ff      <= we4_in;
         s4_blend_ff <= ctrl3_ff.blend;
      end
   end

   assign rsp_valid        = v4_ff;
   assign rsp_pixel_color  = color4_ff;
   assign rsp_write_enable = we4_ff;

   // checks on pipeline behavior
   `TMSB_ASSERT_SAME(a_transparent_black, rsp_valid && !rsp_write_enable, rsp_pixel_color == '0)
   `TMSB_ASSERT_NEXT(a_accept_fills_s1, req_valid && req_ready, v1_ff)
   `TMSB_ASSERT_NEXT(a_s3_stall_holds, v3_ff && !rdy4, v3_ff && $stable(s3_front_ff))
   `TMSB_ASSERT_SAME(a_blend_expanded,
                     rsp_valid && s4_blend_ff && rsp_write_enable,
                     rsp_pixel_color[18:16] == rsp_pixel_color[23:21])
   `TMSB_ASSERT_SAME(a_empty_is_ready, !v1_ff, req_ready)

endmodule

`default_nettype wire

// ===== test/texel_modulate_and_semi_blend_tb.sv =====
// testbench for the texel modulate and semi blend fragment colour pipeline
// depends on tmsb_pkg and texel_modulate_and_semi_blend; checks pixels against a predictor
`timescale 1ns / 1ps

module texel_modulate_and_semi_blend_tb;
   import tmsb_pkg::*;

   localparam int RANDOM_FRAGMENTS = 1000;
   localparam int CYCLE_LIMIT      = 500000;
   localparam int DRAIN_CYCLES     = 12;
   localparam int MAX_REPORTS      = 10;

   // one fragment as presented on the request channel
   typedef struct {
      logic [15:0]    texel;
      logic [7:0]     shade_red;
      logic [7:0]     shade_green;
      logic [7:0]     shade_blue;
      logic           textured;
      logic           raw_texture;
      logic           semi_enable;
      blend_mode_type blend_mode;
      logic [23:0]    back_color;
   } fragment_type;

   // one written pixel as seen on the response channel
   typedef struct {
      logic [23:0] color;
      logic        write_enable;
   } pixel_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [15:0]         req_texel = '0;
   logic [7:0]          req_shade_red = '0;
   logic [7:0]          req_shade_green = '0;
   logic [7:0]          req_shade_blue = '0;
   logic                req_textured = 1'b0;
   logic                req_raw_texture = 1'b0;
   logic                req_semi_enable = 1'b0;
   blend_mode_type      req_blend_mode = BLEND_AVERAGE;
   logic [23:0]         req_back_color = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [23:0]         rsp_pixel_color;
   logic                rsp_write_enable;

   fragment_type pending_fragments[$];
   pixel_type    expected_pixels[$];
   fragment_type current_fragment;
   int        send_gap;
   int        stall_left;
   int        calm_left;
   int        mismatch_count;
   int        cycle_count;

   texel_modulate_and_semi_blend dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_texel        (req_texel),
      .req_shade_red    (req_shade_red),
      .req_shade_green  (req_shade_green),
      .req_shade_blue   (req_shade_blue),
      .req_textured     (req_textured),
      .req_raw_texture  (req_raw_texture),
      .req_semi_enable  (req_semi_enable),
      .req_blend_mode   (req_blend_mode),
      .req_back_color   (req_back_color),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_color  (rsp_pixel_color),
      .rsp_write_enable (rsp_write_enable)
   );

   // clock generation
   always #5 clock = ~clock;

   // widen a 5 bit channel to 8 bits by replicating its top bits
   function automatic logic [7:0] widen5(input logic [4:0] x);
      logic [7:0] w;
      w = {x, 3'b000} | {5'b00000, x[4:2]};
      return w;
   endfunction

   // texel channel times shade over 128, saturated
   function automatic logic [7:0] modulate(input logic [7:0] t, input logic [7:0] s);
      logic [15:0] prod;
      prod = {8'h00, t} * {8'h00, s};
      return (prod[15:7] > 9'd255) ? 8'd255 : prod[14:7];
   endfunction

   // one channel blended at 5 bit precision with the background
   function automatic logic [7:0] blend_channel(input logic [7:0] back8, input logic [7:0] front8,
                                                input blend_mode_type mode);
      int bk;
      int fr;
      int mix;
      bk = int'(back8[7:3]);
      fr = int'(front8[7:3]);
      case (mode)
         BLEND_AVERAGE: mix = (bk + fr) / 2;
         BLEND_ADD:     mix = bk + fr;
         BLEND_SUB:     mix = bk - fr;
         default:       mix = bk + fr / 4;
      endcase
      if (mix < 0) mix = 0;
      if (mix > 31) mix = 31;
      return widen5(mix[4:0]);
   endfunction

   // full colour path of one fragment
   function automatic pixel_type shade_and_blend(input fragment_type f);
      pixel_type  p;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       mixes;
      p.color = '0;
      p.write_enable = 1'b1;
      if (f.textured) begin
         if (f.texel == 16'h0000) begin
            p.write_enable = 1'b0;
            return p;
         end
         red   = widen5(f.texel[4:0]);
         green = widen5(f.texel[9:5]);
         blue  = widen5(f.texel[14:10]);
         if (!f.raw_texture) begin
            red   = modulate(red, f.shade_red);
            green = modulate(green, f.shade_green);
            blue  = modulate(blue, f.shade_blue);
         end
         mixes = f.semi_enable && f.texel[15];
      end else begin
         red   = f.shade_red;
         green = f.shade_green;
         blue  = f.shade_blue;
         mixes = f.semi_enable;
      end
      if (mixes) begin
         red   = blend_channel(f.back_color[23:16], red, f.blend_mode);
         green = blend_channel(f.back_color[15:8], green, f.blend_mode);
         blue  = blend_channel(f.back_color[7:0], blue, f.blend_mode);
      end
      p.color = {red, green, blue};
      return p;
   endfunction

   // idle length: mostly short, a few long, with calm stretches of none
   function automatic int idle_length();
      int pick;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic add_fragment(input logic [15:0] texel, input logic [7:0] sr,
                               input logic [7:0] sg, input logic [7:0] sb,
                               input logic textured, input logic raw, input logic semi,
                               input blend_mode_type mode, input logic [23:0] back);
      fragment_type f;
      f.texel = texel;
      f.shade_red = sr;
      f.shade_green = sg;
      f.shade_blue = sb;
      f.textured = textured;
      f.raw_texture = raw;
      f.semi_enable = semi;
      f.blend_mode = mode;
      f.back_color = back;
      pending_fragments.push_back(f);
   endtask

   // random fragment, biased toward textured and special texels
   function automatic fragment_type random_fragment();
      fragment_type f;
      int        pick;
      f.textured = ($urandom_range(0, 99) < 70);
      pick = $urandom_range(0, 19);
      if (pick == 0) f.texel = 16'h0000;
      else if (pick == 1) f.texel = 16'h8000;
      else f.texel = 16'($urandom);
      f.shade_red   = 8'($urandom);
      f.shade_green = 8'($urandom);
      f.shade_blue  = 8'($urandom);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         f.shade_red = 8'd128;
         f.shade_green = 8'd128;
         f.shade_blue = 8'd128;
      end else if (pick == 1) begin
         f.shade_red = 8'd255;
         f.shade_blue = 8'd0;
      end
      f.raw_texture = 1'($urandom_range(0, 1));
      f.semi_enable = 1'($urandom_range(0, 1));
      f.blend_mode  = blend_mode_type'($urandom_range(0, 3));
      f.back_color  = 24'($urandom);
      return f;
   endfunction

   // driver: present pending fragments, predict each accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_pixels.push_back(shade_and_blend(current_fragment));
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_fragments.size() > 0) begin
               current_fragment = pending_fragments.pop_front();
               req_texel       <= current_fragment.texel;
               req_shade_red   <= current_fragment.shade_red;
               req_shade_green <= current_fragment.shade_green;
               req_shade_blue  <= current_fragment.shade_blue;
               req_textured    <= current_fragment.textured;
               req_raw_texture <= current_fragment.raw_texture;
               req_semi_enable <= current_fragment.semi_enable;
               req_blend_mode  <= current_fragment.blend_mode;
               req_back_color  <= current_fragment.back_color;
               req_valid       <= 1'b1;
               send_gap = idle_length();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = idle_length();
      end
   end

   // monitor: compare each response transaction with the oldest prediction
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected pixel: color %06h write_enable %0b",
                        rsp_pixel_color, rsp_write_enable);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_pixel_color !== want.color || rsp_write_enable !== want.write_enable) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("pixel mismatch: color exp %06h got %06h, %s exp %0b got %0b",
                           want.color, rsp_pixel_color, "write_enable",
                           want.write_enable, rsp_write_enable);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin
      mismatch_count = 0;
      cycle_count = 0;
      calm_left = 0;

      // zero texel, transparent when textured, an ordinary colour when untextured
      add_fragment(16'h0000, 8'd128, 8'd128, 8'd128, 1'b1, 1'b0, 1'b1, BLEND_ADD, 24'hFFFFFF);
      add_fragment(16'h0000, 8'd10, 8'd20, 8'd30, 1'b0, 1'b1, 1'b0, BLEND_AVERAGE, 24'h123456);
      // semi mark alone is opaque black, and with blending on it blends black onto the background
      add_fragment(16'h8000, 8'd128, 8'd128, 8'd128, 1'b1, 1'b0, 1'b0, BLEND_ADD, 24'hFFFFFF);
      add_fragment(16'h8000, 8'd128, 8'd128, 8'd128, 1'b1, 1'b0, 1'b1, BLEND_ADD, 24'h808080);
      // raw full white and unity modulation
      add_fragment(16'hFFFF, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b0, BLEND_AVERAGE, 24'h000000);
      add_fragment(16'h7FFF, 8'd128, 8'd128, 8'd128, 1'b1, 1'b0, 1'b0, BLEND_AVERAGE, 24'h0);
      // saturation at full shade, zero shade
      add_fragment(16'h7FFF, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 1'b0, BLEND_SUB, 24'h0);
      add_fragment(16'h7FFF, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0, BLEND_SUB, 24'h0);
      add_fragment(16'h2A1F, 8'd200, 8'd64, 8'd129, 1'b1, 1'b0, 1'b0, BLEND_QUARTER, 24'h0);
      // semi enabled but texel without mark does not blend
      add_fragment(16'h4210, 8'd128, 8'd128, 8'd128, 1'b1, 1'b0, 1'b1, BLEND_ADD, 24'hFFFFFF);
      // marked texel, every blend mode
      add_fragment(16'hC631, 8'd128, 8'd128, 8'd128, 1'b1, 1'b0, 1'b1, BLEND_AVERAGE, 24'hF00F80);
      add_fragment(16'hFFFF, 8'd128, 8'd128, 8'd128, 1'b1, 1'b1, 1'b1, BLEND_ADD, 24'hFFFFFF);
      add_fragment(16'hFFFF, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 1'b1, BLEND_SUB, 24'h000000);
      add_fragment(16'hFFFF, 8'd90, 8'd255, 8'd1, 1'b1, 1'b0, 1'b1, BLEND_QUARTER, 24'h7F3AC4);
      // untextured flat colour, texel and raw ignored
      add_fragment(16'h0000, 8'd255, 8'd0, 8'd127, 1'b0, 1'b1, 1'b0, BLEND_SUB, 24'hABCDEF);
      add_fragment(16'hFFFF, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0, BLEND_ADD, 24'h0);
      // untextured blending in every mode, clamps at both ends
      add_fragment(16'h0000, 8'd255, 8'd0, 8'd77, 1'b0, 1'b1, 1'b1, BLEND_AVERAGE, 24'h00FF33);
      add_fragment(16'h1234, 8'd255, 8'd255, 8'd8, 1'b0, 1'b0, 1'b1, BLEND_ADD, 24'hFFFF08);
      add_fragment(16'h0000, 8'd255, 8'd7, 8'd100, 1'b0, 1'b0, 1'b1, BLEND_SUB, 24'h00FF64);
      add_fragment(16'h8000, 8'd255, 8'd255, 8'd3, 1'b0, 1'b1, 1'b1, BLEND_QUARTER, 24'hFFF8FF);
      // single-channel texels
      add_fragment(16'h801F, 8'd128, 8'd64, 8'd32, 1'b1, 1'b0, 1'b1, BLEND_AVERAGE, 24'h555555);
      add_fragment(16'h83E0, 8'd128, 8'd255, 8'd32, 1'b1, 1'b0, 1'b1, BLEND_SUB, 24'hAAAAAA);
      add_fragment(16'hFC00, 8'd1, 8'd1, 8'd255, 1'b1, 1'b0, 1'b1, BLEND_QUARTER, 24'h0F0F0F);
      add_fragment(16'h0001, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 1'b0, BLEND_ADD, 24'h0);

      for (int i = 0; i < RANDOM_FRAGMENTS; i++)
         pending_fragments.push_back(random_fragment());

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // wait for the last transaction to be accepted and answered
      do @(posedge clock); while (pending_fragments.size() != 0 || req_valid);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tmsb_pkg.sv
rtl/tmsb_blend.sv
rtl/texel_modulate_and_semi_blend.sv
test/texel_modulate_and_semi_blend_tb.sv
